### hdl/dotq_pkg.sv
// Package for the deadline ordered timer queue: sizes, codes and a saturating add.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none
package dotq_pkg;
	localparam int NUM_SLOTS = 16;
	localparam int TIME_BITS = 48;
	localparam int SLOT_BITS = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1;
	localparam int CNT_BITS = $clog2(NUM_SLOTS + 1);

	localparam logic [1:0] OP_ADD    = 2'd0;
	localparam logic [1:0] OP_REMOVE = 2'd1;
	localparam logic [1:0] OP_TICK   = 2'd2;
	localparam logic [1:0] OP_NOP    = 2'd3;

	localparam logic [1:0] KIND_ADD     = 2'd0;
	localparam logic [1:0] KIND_REMOVE  = 2'd1;
	localparam logic [1:0] KIND_EXPIRED = 2'd2;
	localparam logic [1:0] KIND_TICK    = 2'd3;

	localparam logic [1:0] ST_OK       = 2'd0;
	localparam logic [1:0] ST_FULL     = 2'd1;
	localparam logic [1:0] ST_NOTFOUND = 2'd2;

	// Saturating add of a time and an interval.
	function automatic logic [TIME_BITS-1:0] sat_add(input logic [TIME_BITS-1:0] a,
			input logic [31:0] b);
		logic [TIME_BITS:0] s;
		s = {1'b0, a} + {{(TIME_BITS+1-32){1'b0}}, b};
		return s[TIME_BITS] ? {TIME_BITS{1'b1}} : s[TIME_BITS-1:0];
	endfunction
endpackage
`default_nettype wire

### hdl/dotq_scan.sv
// Shared scan unit: one slot per cycle, keeps the best candidate so far.
// Depends on dotq_pkg.
`timescale 1ns / 1ps
`default_nettype none
module dotq_scan import dotq_pkg::*; (
	input  wire logic                  clk,
	input  wire logic                  start,
	input  wire logic                  cand,
	input  wire logic [TIME_BITS-1:0]  key_dl,
	input  wire logic [31:0]           key_id,
	input  wire logic                  use_id,
	input  wire logic [SLOT_BITS-1:0]  idx,
	output logic                       found,
	output logic [SLOT_BITS-1:0]       best_idx,
	output logic [TIME_BITS-1:0]       best_dl
);
	logic [31:0] best_id_q;
	logic better;

	// A candidate wins on earlier deadline, then on lower id when use_id is set; ties keep lower index.
	always_comb begin
		better = cand && (!found || key_dl < best_dl ||
			(use_id && key_dl == best_dl && key_id < best_id_q));
	end

	always_ff @(posedge clk) begin
		if (start) begin
			found <= 1'b0;
		end else if (better) begin
			found <= 1'b1;
			best_idx <= idx;
			best_dl <= key_dl;
			best_id_q <= key_id;
		end
	end
endmodule
`default_nettype wire

### hdl/deadline_ordered_timer_queue.sv
// Top level of the deadline ordered timer queue: slot table and sequencer.
// Depends on dotq_pkg and dotq_scan.
//
// channel | direction | handshake      | words
// in      | input     | in_valid/ready | op, now_time, interval, repeat_req, timer_id
// out     | output    | out_valid/ready| kind, status, timer_id_res, deadline, remaining, last
//
// Each slot scan passes over all slots through the single compare unit.
// Add and remove take two scans; a tick takes
// one scan per fired timer, one more scan that finds nothing, and a final
// earliest-deadline scan.
// Reset clears the valid bits and the id counter; no clearing pass is needed.
// Output stalls hold the sequencer; no input is taken until the last word leaves.
`timescale 1ns / 1ps
`default_nettype none
module deadline_ordered_timer_queue import dotq_pkg::*; (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        in_valid,
	output logic             in_ready,
	input  wire logic [1:0]  op,
	input  wire logic [47:0] now_time,
	input  wire logic [31:0] interval,
	input  wire logic        repeat_req,
	input  wire logic [31:0] timer_id,
	output logic             out_valid,
	input  wire logic        out_ready,
	output logic [1:0]       kind,
	output logic [1:0]       status,
	output logic [31:0]      timer_id_res,
	output logic [47:0]      deadline,
	output logic signed [48:0] remaining,
	output logic             last
);
	typedef enum logic [5:0] {
		S_IDLE  = 6'b000001,
		S_FIND  = 6'b000010,
		S_ACT   = 6'b000100,
		S_MIN   = 6'b001000,
		S_EMIT  = 6'b010000,
		S_FIRE  = 6'b100000
	} state_t;

	state_t state_q;
	logic [NUM_SLOTS-1:0] valid_q, fired_q;
	logic [TIME_BITS-1:0] dl_mem [NUM_SLOTS];
	logic [31:0] ivl_mem [NUM_SLOTS];
	logic [31:0] id_mem [NUM_SLOTS];
	logic [NUM_SLOTS-1:0] rep_q;
	logic [31:0] next_id_q;
	logic [1:0] op_q;
	logic [TIME_BITS-1:0] now_q;
	logic [31:0] ivl_q, rid_q;
	logic rep_in_q;
	logic [CNT_BITS-1:0] cnt_q;
	logic [SLOT_BITS-1:0] idx;
	logic scan_start, cand, use_id, found;
	logic [SLOT_BITS-1:0] best_idx;
	logic [TIME_BITS-1:0] best_dl;
	logic [1:0] st_q;
	logic [31:0] rid_res_q;
	logic [47:0] dl_res_q;
	logic scan_done;

	assign idx = cnt_q[SLOT_BITS-1:0];
	assign scan_done = (cnt_q == CNT_BITS'(NUM_SLOTS));
	assign in_ready = (state_q == S_IDLE);

	// Candidate selection for the current scan pass.
	always_comb begin
		cand = 1'b0;
		use_id = 1'b0;
		if (!scan_done) begin
			unique case (state_q)
				S_FIND: begin
					if (op_q == OP_ADD) cand = !valid_q[idx] && !found;
					else cand = valid_q[idx] && id_mem[idx] == rid_q && !found;
				end
				S_MIN: cand = valid_q[idx];
				S_FIRE: begin
					cand = valid_q[idx] && !fired_q[idx] && dl_mem[idx] <= now_q;
					use_id = 1'b1;
				end
				default: cand = 1'b0;
			endcase
		end
	end

	assign scan_start = (state_q == S_IDLE) || (state_q == S_ACT) ||
		(state_q == S_EMIT && out_ready);

	dotq_scan u_scan (
		.clk(clk), .start(scan_start), .cand(cand), .key_dl(dl_mem[idx]),
		.key_id(id_mem[idx]), .use_id(use_id), .idx(idx), .found(found),
		.best_idx(best_idx), .best_dl(best_dl)
	);

	// Time to earliest deadline from the minimum scan.
	logic signed [48:0] rem_val;
	always_comb begin
		if (!found) rem_val = '1;
		else if (best_dl <= now_q) rem_val = '0;
		else rem_val = 49'(best_dl - now_q);
	end

	// Slot table writes.
	always_ff @(posedge clk) begin
		if (state_q == S_ACT && op_q == OP_ADD && found) begin
			dl_mem[best_idx] <= sat_add(now_q, ivl_q);
			ivl_mem[best_idx] <= ivl_q;
			id_mem[best_idx] <= next_id_q + 32'd1;
			rep_q[best_idx] <= rep_in_q;
		end else if (state_q == S_FIRE && scan_done && found && rep_q[best_idx]) begin
			dl_mem[best_idx] <= sat_add(now_q,
				(ivl_mem[best_idx] == 32'd0) ? 32'd1 : ivl_mem[best_idx]);
		end
	end

	// Sequencer.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			valid_q <= '0;
			next_id_q <= '0;
			out_valid <= 1'b0;
		end else begin
			unique case (state_q)
				S_IDLE: begin
					if (in_valid) begin
						op_q <= op;
						now_q <= now_time;
						ivl_q <= interval;
						rep_in_q <= repeat_req;
						rid_q <= timer_id;
						cnt_q <= '0;
						fired_q <= '0;
						if (op == OP_TICK) state_q <= S_FIRE;
						else if (op != OP_NOP) state_q <= S_FIND;
					end
				end
				S_FIND: begin
					if (scan_done) state_q <= S_ACT;
					else cnt_q <= cnt_q + 1'b1;
				end
				S_ACT: begin
					cnt_q <= '0;
					state_q <= S_MIN;
					rid_res_q <= rid_q;
					dl_res_q <= '0;
					st_q <= ST_OK;
					if (op_q == OP_ADD) begin
						if (found) begin
							valid_q[best_idx] <= 1'b1;
							next_id_q <= next_id_q + 32'd1;
							rid_res_q <= next_id_q + 32'd1;
							dl_res_q <= sat_add(now_q, ivl_q);
						end else begin
							st_q <= ST_FULL;
							rid_res_q <= '0;
						end
					end else if (found) begin
						valid_q[best_idx] <= 1'b0;
						dl_res_q <= dl_mem[best_idx];
					end else begin
						st_q <= ST_NOTFOUND;
					end
				end
				S_MIN: begin
					if (scan_done) begin
						out_valid <= 1'b1;
						kind <= (op_q == OP_ADD) ? KIND_ADD :
							(op_q == OP_REMOVE) ? KIND_REMOVE : KIND_TICK;
						status <= (op_q == OP_TICK) ? ST_OK : st_q;
						timer_id_res <= (op_q == OP_TICK) ? 32'd0 : rid_res_q;
						deadline <= (op_q == OP_TICK) ? 48'd0 : dl_res_q;
						remaining <= rem_val;
						last <= 1'b1;
						state_q <= S_EMIT;
					end else cnt_q <= cnt_q + 1'b1;
				end
				S_FIRE: begin
					if (scan_done) begin
						cnt_q <= '0;
						if (found) begin
							fired_q[best_idx] <= 1'b1;
							if (!rep_q[best_idx]) valid_q[best_idx] <= 1'b0;
							out_valid <= 1'b1;
							kind <= KIND_EXPIRED;
							status <= ST_OK;
							timer_id_res <= id_mem[best_idx];
							deadline <= best_dl;
							remaining <= '0;
							last <= 1'b0;
							state_q <= S_EMIT;
						end else begin
							state_q <= S_MIN;
						end
					end else cnt_q <= cnt_q + 1'b1;
				end
				S_EMIT: begin
					if (out_ready) begin
						out_valid <= 1'b0;
						cnt_q <= '0;
						if (last) state_q <= S_IDLE;
						else state_q <= S_FIRE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end
endmodule
`default_nettype wire

### hdl/dotq_checker.sv
// Port-level checker for the deadline ordered timer queue, bound to the top.
// Depends on dotq_pkg.
`timescale 1ns / 1ps
`default_nettype none
module dotq_checker import dotq_pkg::*; (
	input wire logic clk, input wire logic arst_n,
	input wire logic in_ready,
	input wire logic out_valid, input wire logic out_ready,
	input wire logic [1:0] kind, input wire logic [1:0] status,
	input wire logic signed [48:0] remaining, input wire logic last
);
	// No new word is taken while a result waits.
	a_excl: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> !in_ready) else $error("input ready while output valid");
	// Expired words are never final, carry an ok status and report zero time left.
	a_exp: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && kind == KIND_EXPIRED |-> !last && status == ST_OK && remaining == '0)
		else $error("bad expired word");
	// Non-final words are always of the expired kind.
	a_last: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !last |-> kind == KIND_EXPIRED) else $error("bad non-final word");
	// Output stays valid until taken.
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid) else $error("output dropped");
endmodule

bind deadline_ordered_timer_queue dotq_checker u_chk (
	.clk(clk), .arst_n(arst_n), .in_ready(in_ready),
	.out_valid(out_valid), .out_ready(out_ready), .kind(kind), .status(status),
	.remaining(remaining), .last(last)
);
`default_nettype wire

### test/deadline_ordered_timer_queue_tb.sv
// Testbench for the deadline ordered timer queue: adds, removes and ticks, checked
// word by word against a behavioral timer table kept in the bench.
// Depends on dotq_pkg and the deadline_ordered_timer_queue RTL.
`timescale 1ns / 1ps
`default_nettype none
module deadline_ordered_timer_queue_tb;
	import dotq_pkg::*;

	typedef struct packed {
		logic [1:0]  op;
		logic [47:0] now_time;
		logic [31:0] interval;
		logic        repeat_req;
		logic [31:0] timer_id;
	} cmd_t;

	typedef struct packed {
		logic [1:0]  kind;
		logic [1:0]  status;
		logic [31:0] tid;
		logic [47:0] dl;
		logic [48:0] rem;
		logic        last;
	} word_t;

	localparam logic [47:0] TMAX = {48{1'b1}};

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic in_valid = 1'b0;
	logic in_ready;
	logic [1:0] op = OP_ADD;
	logic [47:0] now_time = '0;
	logic [31:0] interval = '0;
	logic repeat_req = 1'b0;
	logic [31:0] timer_id = '0;
	logic out_valid;
	logic out_ready = 1'b0;
	logic [1:0] kind;
	logic [1:0] status;
	logic [31:0] timer_id_res;
	logic [47:0] deadline;
	logic signed [48:0] remaining;
	logic last;

	deadline_ordered_timer_queue dut (.*);

	// Timer table mirror.
	logic        tv [NUM_SLOTS];
	logic [47:0] tdl [NUM_SLOTS];
	logic [31:0] tivl [NUM_SLOTS];
	logic        trep [NUM_SLOTS];
	logic [31:0] tidv [NUM_SLOTS];
	logic [31:0] id_count;

	cmd_t  pending_cmds[$];
	word_t expected_words[$];
	int    failures = 0;
	bit    stim_done = 0;
	logic [47:0] clock_now = 0;

	function automatic logic [47:0] add_sat(logic [47:0] a, logic [31:0] b);
		logic [48:0] s;
		s = {1'b0, a} + {17'b0, b};
		return s[48] ? TMAX : s[47:0];
	endfunction

	function automatic logic [48:0] time_to_next(logic [47:0] now);
		logic any;
		logic [47:0] best;
		any = 0;
		best = 0;
		for (int i = 0; i < NUM_SLOTS; i++)
			if (tv[i] && (!any || tdl[i] < best)) begin
				best = tdl[i];
				any = 1;
			end
		if (!any)
			return {49{1'b1}};
		if (best <= now)
			return 0;
		return {1'b0, best - now};
	endfunction

	// Update the table for one accepted word and queue the words it causes.
	task automatic apply_cmd(cmd_t c);
		int i;
		int b;
		logic fired [NUM_SLOTS];
		i = 0;
		if (c.op == OP_ADD) begin
			while (i < NUM_SLOTS && tv[i])
				i++;
			if (i == NUM_SLOTS) begin
				expected_words.push_back({KIND_ADD, ST_FULL, 32'd0, 48'd0,
					time_to_next(c.now_time), 1'b1});
			end else begin
				id_count = id_count + 1;
				tv[i] = 1;
				tdl[i] = add_sat(c.now_time, c.interval);
				tivl[i] = c.interval;
				trep[i] = c.repeat_req;
				tidv[i] = id_count;
				expected_words.push_back({KIND_ADD, ST_OK, id_count, tdl[i],
					time_to_next(c.now_time), 1'b1});
			end
		end else if (c.op == OP_REMOVE) begin
			while (i < NUM_SLOTS && !(tv[i] && tidv[i] == c.timer_id))
				i++;
			if (i == NUM_SLOTS) begin
				expected_words.push_back({KIND_REMOVE, ST_NOTFOUND, c.timer_id, 48'd0,
					time_to_next(c.now_time), 1'b1});
			end else begin
				tv[i] = 0;
				expected_words.push_back({KIND_REMOVE, ST_OK, c.timer_id, tdl[i],
					time_to_next(c.now_time), 1'b1});
			end
		end else if (c.op == OP_TICK) begin
			for (int k = 0; k < NUM_SLOTS; k++)
				fired[k] = 0;
			// Fire expired timers in deadline then id order, each at most once.
			forever begin
				b = -1;
				for (int k = 0; k < NUM_SLOTS; k++) begin
					if (!tv[k] || fired[k] || tdl[k] > c.now_time)
						continue;
					if (b < 0 || tdl[k] < tdl[b] || (tdl[k] == tdl[b] && tidv[k] < tidv[b]))
						b = k;
				end
				if (b < 0)
					break;
				fired[b] = 1;
				expected_words.push_back({KIND_EXPIRED, ST_OK, tidv[b], tdl[b],
					49'd0, 1'b0});
				if (trep[b])
					tdl[b] = add_sat(c.now_time, (tivl[b] != 0) ? tivl[b] : 32'd1);
				else
					tv[b] = 0;
			end
			expected_words.push_back({KIND_TICK, ST_OK, 32'd0, 48'd0,
				time_to_next(c.now_time), 1'b1});
		end
	endtask

	function automatic logic [31:0] pick_interval();
		case ($urandom_range(0, 5))
			0: return 0;
			1: return $urandom;
			2: return {$urandom} | 32'h8000_0000;
			default: return $urandom_range(1, 200);
		endcase
	endfunction

	function automatic cmd_t make_cmd(logic [1:0] o, logic [47:0] t, logic [31:0] iv,
			logic r, logic [31:0] id);
		cmd_t c;
		c.op = o;
		c.now_time = t;
		c.interval = iv;
		c.repeat_req = r;
		c.timer_id = id;
		return c;
	endfunction

	// Clock.
	initial begin
		forever #5 clk = ~clk;
	end

	// Stimulus: directed corners, then random traffic with time moving forward.
	initial begin
		logic [1:0] o;
		int rr;
		for (int k = 0; k < NUM_SLOTS; k++)
			tv[k] = 0;
		id_count = 0;
		// Tick and remove on an empty table, and an unused op that is ignored.
		pending_cmds.push_back(make_cmd(OP_TICK, 48'd0, 32'd0, 1'b0, 32'd0));
		pending_cmds.push_back(make_cmd(OP_REMOVE, 48'd5, 32'hFFFF_FFFF, 1'b1, 32'd7));
		pending_cmds.push_back(make_cmd(OP_NOP, TMAX, 32'hFFFF_FFFF, 1'b1, 32'hFFFF_FFFF));
		// Fill the table, including zero and maximal intervals, then overflow it.
		for (int k = 0; k < NUM_SLOTS + 1; k++)
			pending_cmds.push_back(make_cmd(OP_ADD, 48'd10,
				(k == 0) ? 32'd0 : (k == 1) ? 32'hFFFF_FFFF : 32'd5 * k, k[0], 32'd0));
		// Remove one, then tick so that several fire.
		pending_cmds.push_back(make_cmd(OP_REMOVE, 48'd20, 32'd0, 1'b0, 32'd3));
		pending_cmds.push_back(make_cmd(OP_TICK, 48'd60, 32'd0, 1'b0, 32'd0));
		// Deadline saturation at the top of time and a tick there.
		pending_cmds.push_back(make_cmd(OP_ADD, TMAX - 48'd3, 32'hFFFF_FFFF, 1'b1, 32'd0));
		pending_cmds.push_back(make_cmd(OP_TICK, TMAX, 32'd0, 1'b0, 32'd0));
		pending_cmds.push_back(make_cmd(OP_REMOVE, TMAX, 32'd0, 1'b0, 32'hFFFF_FFFF));
		pending_cmds.push_back(make_cmd(OP_TICK, TMAX, 32'd0, 1'b0, 32'd0));
		// Random phase restarts time low; repeating timers left at the top of time
		// stay in the table until removed.
		clock_now = 0;
		for (int n = 0; n < 260; n++) begin
			rr = $urandom_range(0, 9);
			o = (rr < 4) ? OP_ADD : (rr < 6) ? OP_REMOVE : OP_TICK;
			if ($urandom_range(0, 3) == 0)
				clock_now = clock_now + $urandom_range(0, 400);
			if (n == 200)
				clock_now = TMAX - 48'd500;
			pending_cmds.push_back(make_cmd(o, clock_now, pick_interval(),
				1'($urandom_range(0, 1)),
				($urandom_range(0, 4) == 0) ? $urandom : $urandom_range(0, 300)));
		end
		// Final tick at the top of time clears everything except repeats.
		pending_cmds.push_back(make_cmd(OP_TICK, TMAX, 32'd0, 1'b0, 32'd0));
	end

	// Reset, then release.
	initial begin
		repeat (5) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
	end

	// Input acceptance seen at the last rising edge.
	logic in_acc_q = 1'b0;
	always @(posedge clk) begin
		in_acc_q <= in_valid && in_ready;
	end

	// Driver: bursts of back-to-back words separated by random gaps.
	int burst_left = 0;
	int gap_left = 0;
	always @(negedge clk) begin
		if (arst_n && !(in_valid && !in_acc_q)) begin
			if (gap_left > 0) begin
				gap_left <= gap_left - 1;
				in_valid <= 1'b0;
			end else if (pending_cmds.size() > 0) begin
				cmd_t c;
				c = pending_cmds.pop_front();
				op <= c.op;
				now_time <= c.now_time;
				interval <= c.interval;
				repeat_req <= c.repeat_req;
				timer_id <= c.timer_id;
				in_valid <= 1'b1;
				if (burst_left > 0)
					burst_left <= burst_left - 1;
				else begin
					burst_left <= $urandom_range(0, 8);
					gap_left <= ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 40);
				end
			end else begin
				in_valid <= 1'b0;
				stim_done <= 1'b1;
			end
		end
	end

	// Receiver stalls: repeating windows of steady accept, steady stall and random stall.
	int stall_phase = 0;
	always @(negedge clk) begin
		stall_phase <= (stall_phase + 1) % 97;
		if (stall_phase < 30)
			out_ready <= 1'b1;
		else if (stall_phase < 40)
			out_ready <= 1'b0;
		else
			out_ready <= ($urandom_range(0, 2) != 0);
	end

	// Monitor: predict on accepted input words, check accepted output words.
	always @(posedge clk) begin
		if (arst_n) begin
			if (in_valid && in_ready)
				apply_cmd({op, now_time, interval, repeat_req, timer_id});
			if (out_valid && out_ready) begin
				if (expected_words.size() == 0) begin
					$error("unexpected word kind=%0d id=%0d", kind, timer_id_res);
					failures++;
				end else begin
					word_t e;
					e = expected_words.pop_front();
					if (kind !== e.kind) begin
						$error("kind expected %0d actual %0d", e.kind, kind);
						failures++;
					end
					if (status !== e.status) begin
						$error("status expected %0d actual %0d", e.status, status);
						failures++;
					end
					if (timer_id_res !== e.tid) begin
						$error("timer_id_res expected %0d actual %0d", e.tid, timer_id_res);
						failures++;
					end
					if (deadline !== e.dl) begin
						$error("deadline expected %0d actual %0d", e.dl, deadline);
						failures++;
					end
					if (remaining !== e.rem) begin
						$error("remaining expected %0d actual %0d", $signed(e.rem), remaining);
						failures++;
					end
					if (last !== e.last) begin
						$error("last expected %0d actual %0d", e.last, last);
						failures++;
					end
				end
			end
		end
	end

	// End of run: drain, then a quiet stretch to catch stray words.
	initial begin
		wait (stim_done);
		while (expected_words.size() != 0)
			@(posedge clk);
		repeat (2000) @(posedge clk);
		if (failures == 0 && expected_words.size() == 0)
			$display("deadline_ordered_timer_queue_tb: PASS");
		else
			$display("deadline_ordered_timer_queue_tb: FAIL");
		$finish;
	end

	// Watchdog.
	initial begin
		#50ms;
		$display("deadline_ordered_timer_queue_tb: FAIL");
		$finish;
	end
endmodule
`default_nettype wire

### filelist.f
hdl/dotq_pkg.sv
hdl/dotq_scan.sv
hdl/deadline_ordered_timer_queue.sv
hdl/dotq_checker.sv
test/deadline_ordered_timer_queue_tb.sv
